// ===== rtl/waveguide_clarinet_voice_macros.svh =====
// Assertion macros shared by the clarinet voice RTL.
`ifndef WAVEGUIDE_CLARINET_VOICE_MACROS_SVH
`define WAVEGUIDE_CLARINET_VOICE_MACROS_SVH
`ifndef SYNTHESIS
`define WCV_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WCV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) ante |-> cons) else $error(msg);
`else
`define WCV_ASSERT(label, clk, rst_n, prop, msg)
`define WCV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/wcv_pkg.sv =====
// Package with widths, constants, types and helpers of the clarinet voice.
`timescale 1ns / 1ps
package wcv_pkg;
	localparam int IN_W        = 18;
	localparam int SMP_W       = 16;
	localparam int LEN_W       = 9;
	localparam int REFL_W      = 18;
	localparam int DIFF_W      = 19;
	localparam int MUL_W       = 31;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int SUM_W       = 38;
	localparam int RECIP_SHIFT = 41;
	localparam int Q_W         = 18;
	localparam int N_W         = 29;
	localparam int SAT_W       = 22;
	localparam int MAX_DELAY_DEF = 256;

	localparam logic [LEN_W-1:0]          DELAY_LEN_RESET = 9'd66;
	localparam logic signed [REFL_W-1:0]  REFL_ONE        = 18'sd65536;
	localparam logic signed [REFL_W+1:0]  REFL_HI_X       = 20'sd65536;
	localparam logic signed [REFL_W+1:0]  REFL_LO_X       = -20'sd65536;
	localparam logic signed [REFL_W+1:0]  REST_REFL       = 20'sd52429;
	localparam logic signed [REFL_W+1:0]  DIV_BIAS        = 20'sd117967;
	localparam logic [MUL_W-2:0]          RECIP_M         = 30'd703687442;
	localparam logic signed [DIFF_W-1:0]  D_HI            = 19'sd10001;
	localparam logic signed [DIFF_W-1:0]  D_LO            = -19'sd90001;
	localparam logic signed [31:0]        N_BIAS          = 32'sd368646875;
	localparam logic signed [SAT_W-1:0]   SMP_MAX         = 22'sd32767;
	localparam logic signed [SAT_W-1:0]   SMP_MIN         = -22'sd32768;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAP,
		ST_REFL,
		ST_WB1,
		ST_WB2,
		ST_WR
	} state_t;

	typedef struct packed {
		logic             rd;
		logic             wr;
		logic [SMP_W-1:0] wr_data;
	} ring_ctl_t;

	function automatic logic signed [SMP_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
		logic signed [SMP_W-1:0] r;
		if (v > SMP_MAX) begin
			r = SMP_MAX[SMP_W-1:0];
		end else if (v < SMP_MIN) begin
			r = SMP_MIN[SMP_W-1:0];
		end else begin
			r = v[SMP_W-1:0];
		end
		return r;
	endfunction
endpackage

// ===== rtl/wcv_mul.sv =====
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module wcv_mul (
	input  logic                               clk,
	input  logic signed [wcv_pkg::MUL_W-1:0]   a,
	input  logic signed [wcv_pkg::MUL_W-1:0]   b,
	output logic signed [wcv_pkg::PROD_W-1:0]  prod_q
);
	import wcv_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end
endmodule

// ===== rtl/wcv_ring.sv =====
// Bore delay ring: memory, ring position, clearing sweep after reset.
`timescale 1ns / 1ps
`include "waveguide_clarinet_voice_macros.svh"
module wcv_ring #(
	parameter int MAX_DELAY = wcv_pkg::MAX_DELAY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wcv_pkg::ring_ctl_t              ctl,
	input  logic [wcv_pkg::LEN_W-1:0]       len,
	output logic [wcv_pkg::SMP_W-1:0]       rd_data_q,
	output logic                            ring_ready
);
	import wcv_pkg::*;

	localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
	localparam int CW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;

	logic [SMP_W-1:0] mem [MAX_DELAY];
	logic [AW-1:0]    pos_q;
	logic [AW-1:0]    clr_cnt_q;
	logic             clear_done_q;
	logic [CW-1:0]    pos_nxt;
	logic             wrap;
	logic             mem_we;
	logic [AW-1:0]    mem_addr;
	logic [SMP_W-1:0] mem_wdata;

	assign ring_ready = clear_done_q;
	assign pos_nxt    = CW'(pos_q) + CW'(1);
	assign wrap       = (pos_nxt >= CW'(MAX_DELAY)) || (pos_nxt >= CW'(len));
	assign mem_we     = !clear_done_q || ctl.wr;
	assign mem_addr   = clear_done_q ? pos_q : clr_cnt_q;
	assign mem_wdata  = clear_done_q ? ctl.wr_data : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q    <= '0;
			clear_done_q <= 1'b0;
			pos_q        <= '0;
		end else begin
			if (!clear_done_q) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
				if (clr_cnt_q == AW'(MAX_DELAY - 1)) begin
					clear_done_q <= 1'b1;
				end
			end else if (ctl.wr) begin
				pos_q <= wrap ? '0 : pos_nxt[AW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_data_q <= mem[pos_q];
		end
	end

	`WCV_ASSERT_IMP(a_no_access_in_clear, clk, arst_n, !clear_done_q, !ctl.rd && !ctl.wr, "ring accessed during clearing sweep")
	`WCV_ASSERT(a_pos_in_range, clk, arst_n, (AW + 1)'(pos_q) < (AW + 1)'(MAX_DELAY), "ring position out of range")
	`WCV_ASSERT_IMP(a_clear_full_sweep, clk, arst_n, $rose(clear_done_q), $past(clr_cnt_q == AW'(MAX_DELAY - 1)), "clearing sweep ended early")
endmodule

// ===== rtl/waveguide_clarinet_voice.sv =====
// Top level of the waveguide clarinet voice: sequencer, reed and bell datapath.
`timescale 1ns / 1ps
`include "waveguide_clarinet_voice_macros.svh"
// Waveguide clarinet voice. Each input word is one sample tick carrying the
// breath pressure; each one gives exactly one output word with the bell sample
// and the bell sample times twenty, saturated. After reset the block sweeps all
// MAX_DELAY entries of the bore delay memory to zero and takes no input word
// until the sweep ends; configuration writes are taken at any time. An item goes,
// from acceptance until the next word can be accepted, through one delay memory read,
// then three passes through the single shared 31x31 multiplier (reciprocal
// divide for the reed reflection, then the two products of the bore write-back)
// and a write-back step. A finished result waits in an output register, so
// the next word is accepted while it is still pending; the following result then
// holds in write-back until the pending word is taken. delay_length sets the
// active ring length; 0 acts as 1 and values above MAX_DELAY act as MAX_DELAY.
module waveguide_clarinet_voice #(
	parameter int MAX_DELAY = wcv_pkg::MAX_DELAY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [wcv_pkg::IN_W-1:0]     breath_pressure,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [wcv_pkg::SMP_W-1:0]    audio_sample,
	output logic signed [wcv_pkg::SMP_W-1:0]    bell_sample,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wcv_pkg::LEN_W-1:0]           cfg_data
);
	import wcv_pkg::*;

	state_t state_q, state_d;

	logic [LEN_W-1:0]          delay_length_q;
	logic signed [IN_W-1:0]    p_q;
	logic signed [SMP_W-1:0]   prev_q;
	logic signed [SMP_W-1:0]   bell_q;
	logic signed [REFL_W-1:0]  refl_q;
	logic signed [SUM_W-1:0]   acc_q;
	logic                      out_valid_q;
	logic signed [SMP_W-1:0]   audio_q;
	logic signed [SMP_W-1:0]   bell_out_q;

	ring_ctl_t                 ring_ctl;
	logic [SMP_W-1:0]          ring_rd_data;
	logic                      ring_ready;

	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0]  prod_q;

	logic signed [SMP_W-1:0]   tap;
	logic signed [SMP_W:0]     pair_sum;
	logic signed [SMP_W:0]     pair_adj;
	logic signed [SMP_W-1:0]   bell_c;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [DIFF_W-1:0]  diff_c;
	logic signed [31:0]        n_wide;
	logic [Q_W-1:0]            quot;
	logic signed [REFL_W+1:0]  refl_raw;
	logic signed [REFL_W-1:0]  refl_c;
	logic signed [SUM_W-1:0]   wsum;
	logic signed [SUM_W-1:0]   wadj;
	logic signed [SMP_W-1:0]   w_sat;
	logic signed [SAT_W-1:0]   bell_x20;
	logic                      accept;
	logic                      commit;

	assign cfg_ready    = 1'b1;
	assign in_ready     = (state_q == ST_IDLE) && ring_ready;
	assign accept       = in_valid && in_ready;
	assign commit       = (state_q == ST_WR) && (!out_valid_q || out_ready);
	assign out_valid    = out_valid_q;
	assign audio_sample = audio_q;
	assign bell_sample  = bell_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_length_q <= DELAY_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			delay_length_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ring_ctl.rd  = 1'b0;
		ring_ctl.wr  = 1'b0;
		ring_ctl.wr_data = w_sat;
		mul_a        = '0;
		mul_b        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ring_ctl.rd = 1'b1;
					state_d     = ST_TAP;
				end
			end
			ST_TAP: begin
				mul_a   = MUL_W'({2'b00, n_wide[N_W-1:0]});
				mul_b   = MUL_W'({1'b0, RECIP_M});
				state_d = ST_REFL;
			end
			ST_REFL: begin
				state_d = ST_WB1;
			end
			ST_WB1: begin
				mul_a   = MUL_W'(0) - {{(MUL_W-REFL_W){refl_q[REFL_W-1]}}, refl_q};
				mul_b   = {{(MUL_W-SMP_W){bell_q[SMP_W-1]}}, bell_q};
				state_d = ST_WB2;
			end
			ST_WB2: begin
				mul_a   = {{(MUL_W-REFL_W){1'b0}}, REFL_ONE}
					- {{(MUL_W-REFL_W){refl_q[REFL_W-1]}}, refl_q};
				mul_b   = {{(MUL_W-IN_W){p_q[IN_W-1]}}, p_q};
				state_d = ST_WR;
			end
			ST_WR: begin
				// hold the second product while the write-back waits
				mul_a   = {{(MUL_W-REFL_W){1'b0}}, REFL_ONE}
					- {{(MUL_W-REFL_W){refl_q[REFL_W-1]}}, refl_q};
				mul_b   = {{(MUL_W-IN_W){p_q[IN_W-1]}}, p_q};
				if (commit) begin
					ring_ctl.wr = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		tap      = $signed(ring_rd_data);
		pair_sum = {tap[SMP_W-1], tap} + {prev_q[SMP_W-1], prev_q};
		pair_adj = pair_sum + {{SMP_W{1'b0}}, pair_sum[SMP_W]};
		bell_c   = pair_adj[SMP_W:1];
		diff     = {p_q[IN_W-1], p_q} - {{(DIFF_W-SMP_W){tap[SMP_W-1]}}, tap};
		if (diff > D_HI) begin
			diff_c = D_HI;
		end else if (diff < D_LO) begin
			diff_c = D_LO;
		end else begin
			diff_c = diff;
		end
		n_wide   = {diff_c[DIFF_W-1], diff_c, 12'd0} + N_BIAS;
		quot     = prod_q[RECIP_SHIFT +: Q_W];
		refl_raw = REST_REFL + $signed({2'b00, quot}) - DIV_BIAS;
		if (refl_raw > REFL_HI_X) begin
			refl_c = REFL_HI_X[REFL_W-1:0];
		end else if (refl_raw < REFL_LO_X) begin
			refl_c = REFL_LO_X[REFL_W-1:0];
		end else begin
			refl_c = refl_raw[REFL_W-1:0];
		end
		wsum     = acc_q + prod_q[SUM_W-1:0];
		wadj     = wsum + (wsum[SUM_W-1] ? SUM_W'(65535) : SUM_W'(0));
		w_sat    = sat16(wadj[SUM_W-1:16]);
		bell_x20 = ({{(SAT_W-SMP_W){bell_q[SMP_W-1]}}, bell_q} <<< 4)
			+ ({{(SAT_W-SMP_W){bell_q[SMP_W-1]}}, bell_q} <<< 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (state_q == ST_TAP) begin
			prev_q <= tap;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_q <= breath_pressure;
		end
		if (state_q == ST_TAP) begin
			bell_q <= bell_c;
		end
		if (state_q == ST_REFL) begin
			refl_q <= refl_c;
		end
		if (state_q == ST_WB2) begin
			acc_q <= prod_q[SUM_W-1:0];
		end
		if (commit) begin
			audio_q    <= sat16(bell_x20);
			bell_out_q <= bell_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	wcv_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	wcv_ring #(
		.MAX_DELAY (MAX_DELAY)
	) u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ring_ctl),
		.len        (delay_length_q),
		.rd_data_q  (ring_rd_data),
		.ring_ready (ring_ready)
	);

	`WCV_ASSERT_IMP(a_busy_after_accept, clk, arst_n, accept, ##1 !in_ready, "input taken while an item is in work")
	`WCV_ASSERT_IMP(a_refl_clamped, clk, arst_n, state_q == ST_WB1, (refl_q <= REFL_ONE) && (refl_q >= -REFL_ONE), "reed reflection outside clamp range")
	`WCV_ASSERT_IMP(a_out_from_writeback, clk, arst_n, $rose(out_valid_q), $past(state_q == ST_WR), "output word loaded outside write-back")
endmodule
